FILE: rtl/core/smp_pkg.sv
// ----------------------------------------------------------------------------
// Serpentine module placer package
// Shared types, codes and geometry constants for the placer controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package smp_pkg;

    // Width of the reported module coordinates.
    localparam int CoordBits = 8;
    // Width of the geometry registers.
    localparam int GridBits  = 8;
    // Width of the colour symbol.
    localparam int SymBits   = 2;

    // Configuration port.
    localparam int ApbDataBits = 32;
    localparam int ApbAddrBits = 3;

    // Register index codes, taken from the word address.
    localparam logic RegGridRows = 1'b0;
    localparam logic RegGridCols = 1'b1;

    // Reset geometry.
    localparam logic [GridBits-1:0] GridRowsReset = 8'd108;
    localparam logic [GridBits-1:0] GridColsReset = 8'd192;

    // Request kinds.
    localparam logic KindStartFrame = 1'b0;
    localparam logic KindSymbol     = 1'b1;

    // Reserved zone geometry: finder corners and the alignment zone offsets
    // measured back from the far edges.
    localparam int FinderSize = 8;
    localparam int AlignNear  = 6;
    localparam int AlignFar   = 2;

    // Signed coordinate used for the reserved cell compares.
    typedef logic signed [GridBits+1:0] t_scoord;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start_frame;
        logic latch_sym;
        logic step;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/core/smp_ctrl.sv
// ----------------------------------------------------------------------------
// Serpentine module placer controller
// Accepts requests, runs the module walk one cell per cycle and hands a
// result to the output register once a free module or a full frame is seen.
// ----------------------------------------------------------------------------
module smp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_kind,
    output logic            o_in_ready,
    input  smp_pkg::t_dp_sts i_sts,
    output smp_pkg::t_dp_cmd o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StWalk = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    // The block takes a new request whenever it is not walking.
    assign o_in_ready = (r_state == StIdle);
    assign w_accept   = i_in_valid && o_in_ready;

    // Command decode and next state.
    always_comb begin
        n_state           = r_state;
        o_cmd.start_frame = 1'b0;
        o_cmd.latch_sym   = 1'b0;
        o_cmd.step        = 1'b0;
        o_cmd.emit        = 1'b0;
        unique case (r_state)
            StIdle: begin
                if (w_accept) begin
                    if (i_kind == smp_pkg::KindSymbol) begin
                        o_cmd.latch_sym = 1'b1;
                        n_state         = StWalk;
                    end else begin
                        o_cmd.start_frame = 1'b1;
                    end
                end
            end
            StWalk: begin
                if (!i_sts.hit) begin
                    o_cmd.step = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/smp_datapath.sv
// ----------------------------------------------------------------------------
// Serpentine module placer datapath
// Holds the cursor, tests one module per cycle against the reserved zones
// and keeps the registered result for the output channel.
// ----------------------------------------------------------------------------
module smp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [smp_pkg::GridBits-1:0]       i_grid_rows,
    input  logic [smp_pkg::GridBits-1:0]       i_grid_cols,
    input  logic [smp_pkg::SymBits-1:0]        i_symbol,
    input  logic                               i_out_ready,
    input  smp_pkg::t_dp_cmd                   i_cmd,
    output smp_pkg::t_dp_sts                   o_sts,
    output logic                               o_out_valid,
    output logic                               o_placed,
    output logic [smp_pkg::CoordBits-1:0]      o_module_row,
    output logic [smp_pkg::CoordBits-1:0]      o_module_col,
    output logic [smp_pkg::SymBits-1:0]        o_symbol_out
);

    // Reserved cell test: finder corners first, then the bottom rows.
    function automatic logic cell_reserved(
        input smp_pkg::t_scoord r,
        input smp_pkg::t_scoord c,
        input smp_pkg::t_scoord rows,
        input smp_pkg::t_scoord cols
    );
        smp_pkg::t_scoord last_f;
        smp_pkg::t_scoord size_f;
        smp_pkg::t_scoord near_a;
        smp_pkg::t_scoord far_a;
        smp_pkg::t_scoord one_s;
        logic             res;
        last_f = smp_pkg::t_scoord'(smp_pkg::FinderSize - 1);
        size_f = smp_pkg::t_scoord'(smp_pkg::FinderSize);
        near_a = smp_pkg::t_scoord'(smp_pkg::AlignNear);
        far_a  = smp_pkg::t_scoord'(smp_pkg::AlignFar);
        one_s  = smp_pkg::t_scoord'(1);
        if (r <= last_f) begin
            res = (c <= last_f) || ((c >= cols - size_f) && (c <= cols - one_s));
        end else if (r < rows - size_f) begin
            res = 1'b0;
        end else if ((r <= rows - one_s) && (c <= last_f)) begin
            res = 1'b1;
        end else begin
            res = (r >= rows - near_a) && (r <= rows - far_a) &&
                  (c >= cols - near_a) && (c <= cols - far_a);
        end
        return res;
    endfunction

    logic [smp_pkg::GridBits-1:0]   r_row;
    logic [smp_pkg::GridBits-1:0]   n_row;
    logic signed [smp_pkg::GridBits:0] r_col;
    logic signed [smp_pkg::GridBits:0] n_col;
    logic [smp_pkg::SymBits-1:0]    r_sym;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic                           r_placed;
    logic [smp_pkg::CoordBits-1:0]  r_mrow;
    logic [smp_pkg::CoordBits-1:0]  r_mcol;
    logic [smp_pkg::SymBits-1:0]    r_msym;

    logic                           w_even;
    logic                           w_full;
    logic                           w_in_range;
    logic                           w_reserved;
    logic signed [smp_pkg::GridBits:0] w_col_fwd;
    logic signed [smp_pkg::GridBits:0] w_col_back;

    // Position tests on the current cursor.
    assign w_even     = ~r_row[0];
    assign w_full     = (r_row >= i_grid_rows);
    assign w_in_range = ~r_col[smp_pkg::GridBits] &&
                        (r_col[smp_pkg::GridBits-1:0] < i_grid_cols);
    assign w_reserved = cell_reserved(smp_pkg::t_scoord'({2'b00, r_row}),
                                      smp_pkg::t_scoord'({r_col[smp_pkg::GridBits], r_col}),
                                      smp_pkg::t_scoord'({2'b00, i_grid_rows}),
                                      smp_pkg::t_scoord'({2'b00, i_grid_cols}));

    // Column moves along the row direction and back at a row turn.
    assign w_col_fwd  = w_even ? r_col + 9'sd1 : r_col - 9'sd1;
    assign w_col_back = w_even ? r_col - 9'sd1 : r_col + 9'sd1;

    // Status to the controller.
    assign o_sts.hit      = w_full || (w_in_range && !w_reserved);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Cursor update.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (i_cmd.start_frame) begin
            n_row = '0;
            n_col = '0;
        end else if (i_cmd.step) begin
            if (w_in_range) begin
                n_col = w_col_fwd;
            end else begin
                n_col = w_col_back;
                n_row = r_row + 8'd1;
            end
        end else if (i_cmd.emit && !w_full) begin
            n_col = w_col_fwd;
        end
    end

    // Output valid: set by a new result, cleared when the result is taken.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    // Control state and cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

    // Symbol capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_sym) begin
            r_sym <= i_symbol;
        end
        if (i_cmd.emit) begin
            r_placed <= !w_full;
            r_mrow   <= w_full ? '0 : r_row;
            r_mcol   <= w_full ? '0 : r_col[smp_pkg::CoordBits-1:0];
            r_msym   <= w_full ? '0 : r_sym;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_placed     = r_placed;
    assign o_module_row = r_mrow;
    assign o_module_col = r_mcol;
    assign o_symbol_out = r_msym;

endmodule

FILE: rtl/core/serpentine_module_placer_top.sv
// ----------------------------------------------------------------------------
// Serpentine module placer
// Places colour symbols on a module grid in serpentine order, skipping the
// finder corners and the alignment zone, with an APB geometry register port.
// ----------------------------------------------------------------------------
// A symbol result is registered once the walk finds a free module or a full
// frame and the output register is free; the walk steps one module per cycle.
// No new request is taken until a symbol's result is handed to the output
// register. A start-frame request gives no result.
// Reset: synchronous, active low; cursor to (0,0), grid 108 x 192, no result.
module serpentine_module_placer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_kind,
    input  logic [smp_pkg::SymBits-1:0]         i_symbol,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_placed,
    output logic [smp_pkg::CoordBits-1:0]       o_module_row,
    output logic [smp_pkg::CoordBits-1:0]       o_module_col,
    output logic [smp_pkg::SymBits-1:0]         o_symbol_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smp_pkg::ApbAddrBits-1:0]     paddr,
    input  logic [smp_pkg::ApbDataBits-1:0]     pwdata,
    output logic [smp_pkg::ApbDataBits-1:0]     prdata,
    output logic                                pready
);

    logic [smp_pkg::GridBits-1:0] r_grid_rows;
    logic [smp_pkg::GridBits-1:0] r_grid_cols;
    logic                         w_cfg_wr;
    logic                         w_reg_idx;
    logic [smp_pkg::GridBits-1:0] w_rd_val;
    smp_pkg::t_dp_cmd             w_cmd;
    smp_pkg::t_dp_sts             w_sts;

    // APB access: zero wait states, register picked by the word address.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[2];

    // Geometry registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= smp_pkg::GridRowsReset;
            r_grid_cols <= smp_pkg::GridColsReset;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                smp_pkg::RegGridRows: r_grid_rows <= pwdata[smp_pkg::GridBits-1:0];
                smp_pkg::RegGridCols: r_grid_cols <= pwdata[smp_pkg::GridBits-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (w_reg_idx)
            smp_pkg::RegGridRows: w_rd_val = r_grid_rows;
            smp_pkg::RegGridCols: w_rd_val = r_grid_cols;
            default:              w_rd_val = '0;
        endcase
    end
    assign prdata = {{(smp_pkg::ApbDataBits - smp_pkg::GridBits){1'b0}}, w_rd_val};

    // Controller.
    smp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    smp_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grid_rows  (r_grid_rows),
        .i_grid_cols  (r_grid_cols),
        .i_symbol     (i_symbol),
        .i_out_ready  (i_out_ready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_placed     (o_placed),
        .o_module_row (o_module_row),
        .o_module_col (o_module_col),
        .o_symbol_out (o_symbol_out)
    );

    // A full-frame result carries no coordinates and no symbol.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_placed) |->
            (o_module_row == '0 && o_module_col == '0 && o_symbol_out == '0))
        else $error("full-frame result with non-zero payload");

    // A placed module lies inside the configured grid.
    a_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_placed) |->
            (o_module_row < r_grid_rows && o_module_col < r_grid_cols))
        else $error("placed module outside the grid");

    // A symbol request starts a walk, so no request is taken in the next cycle.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == smp_pkg::KindSymbol) |=> !o_in_ready)
        else $error("request taken while a walk is running");

endmodule

FILE: dv/tb_serpentine_module_placer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serpentine module placer testbench
// Drives start-frame and symbol requests into the placer under random
// gaps and back-pressure, rewrites the grid geometry over APB between
// phases, and checks every placement result against a behavioural copy of
// the serpentine walk with its reserved finder corners and alignment zone.
// ----------------------------------------------------------------------------
module tb_serpentine_module_placer_top;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 4;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 4000000;

    typedef logic [smp_pkg::GridBits-1:0]    t_grid;
    typedef logic [smp_pkg::SymBits-1:0]     t_sym;
    typedef logic [smp_pkg::CoordBits-1:0]   t_coord;
    typedef logic [smp_pkg::ApbAddrBits-1:0] t_paddr;
    typedef logic [smp_pkg::ApbDataBits-1:0] t_pdata;

    // One placement as the block reports it.
    typedef struct packed {
        logic   placed;
        t_coord mod_row;
        t_coord mod_col;
        t_sym   sym;
    } t_placement;

    typedef enum logic [1:0] {
        ACT_ITEM,
        ACT_WRITE_ROWS,
        ACT_WRITE_COLS
    } t_stim_act;

    // One row of the directed table.
    typedef struct packed {
        t_stim_act  act;
        logic       kind;
        t_sym       sym;
        t_grid      cfg_val;
        logic       fixed;
        t_placement exp;
    } t_stim_row;

    localparam t_placement FRAME_FULL = '0;
    localparam logic       K_SF       = smp_pkg::KindStartFrame;
    localparam logic       K_SYM      = smp_pkg::KindSymbol;

    // Directed table: results are typed in only where obvious, otherwise
    // the walk predictor decides.
    t_stim_row directed_tbl [29] = '{
        '{ACT_ITEM,       K_SYM, 2'd0, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd8, 2'd0}},
        '{ACT_ITEM,       K_SYM, 2'd3, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd9, 2'd3}},
        '{ACT_ITEM,       K_SF,  2'd3, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd2, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd8, 2'd2}},
        '{ACT_ITEM,       K_SYM, 2'd1, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_WRITE_ROWS, K_SYM, 2'd0, 8'd17,  1'b0, FRAME_FULL},
        '{ACT_WRITE_COLS, K_SYM, 2'd0, 8'd17,  1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd0, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd3, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_WRITE_ROWS, K_SYM, 2'd0, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd2, 8'd0,   1'b1, FRAME_FULL},
        '{ACT_ITEM,       K_SF,  2'd1, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd1, 8'd0,   1'b1, FRAME_FULL},
        '{ACT_WRITE_ROWS, K_SYM, 2'd0, 8'd255, 1'b0, FRAME_FULL},
        '{ACT_WRITE_COLS, K_SYM, 2'd0, 8'd255, 1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SF,  2'd0, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd3, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd8, 2'd3}},
        '{ACT_ITEM,       K_SYM, 2'd0, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_WRITE_COLS, K_SYM, 2'd0, 8'd9,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SF,  2'd2, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd1, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd2, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_WRITE_COLS, K_SYM, 2'd0, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd3, 8'd0,   1'b1, FRAME_FULL},
        '{ACT_WRITE_ROWS, K_SYM, 2'd0, 8'd108, 1'b0, FRAME_FULL},
        '{ACT_WRITE_COLS, K_SYM, 2'd0, 8'd192, 1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SF,  2'd1, 8'd0,   1'b0, FRAME_FULL},
        '{ACT_ITEM,       K_SYM, 2'd1, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd8, 2'd1}},
        '{ACT_ITEM,       K_SYM, 2'd2, 8'd0,   1'b1, '{1'b1, 8'd0, 8'd9, 2'd2}}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_kind;
    t_sym                   i_symbol;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic                   o_placed;
    t_coord                 o_module_row;
    t_coord                 o_module_col;
    t_sym                   o_symbol_out;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    t_paddr                 paddr;
    t_pdata                 pwdata;
    t_pdata                 prdata;
    logic                   pready;

    // Typed-in expectation travelling with the request on offer.
    logic                   tag_fixed;
    t_placement             tag_exp;

    // Walk predictor state and its copy of the geometry registers.
    t_grid                  grid_rows_m;
    t_grid                  grid_cols_m;
    int                     cur_row;
    int                     cur_col;

    t_placement             pending_placements [$];
    int                     err_count;
    int                     cycle_count;
    bit                     tx_quiet;
    bit                     hold_req;

    serpentine_module_placer_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_symbol     (i_symbol),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_placed     (o_placed),
        .o_module_row (o_module_row),
        .o_module_col (o_module_col),
        .o_symbol_out (o_symbol_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // A cell is reserved in a finder corner or in the alignment zone; the
    // top rows are tested only against the two top corners.
    function automatic bit cell_is_reserved(int r, int c, int rows, int cols);
        if (r <= 7) begin
            return c <= 7 || (c >= cols - 8 && c <= cols - 1);
        end
        if (r < rows - 8) begin
            return 1'b0;
        end
        if (r <= rows - 1 && c <= 7) begin
            return 1'b1;
        end
        return r >= rows - 6 && r <= rows - 2 && c >= cols - 6 && c <= cols - 2;
    endfunction

    // Advance the serpentine cursor for one request. Returns 1 when the
    // request yields a placement result.
    function automatic bit place_symbol(input logic kind, input t_sym sym,
                                        output t_placement res);
        int rows;
        int cols;
        int r;
        int c;
        bit even;
        rows = int'(grid_rows_m);
        cols = int'(grid_cols_m);
        res  = '0;
        if (kind == smp_pkg::KindStartFrame) begin
            cur_row = 0;
            cur_col = 0;
            return 1'b0;
        end
        while (cur_row < rows) begin
            even = (cur_row & 1) == 0;
            while (cur_col < cols && cur_col >= 0) begin
                r = cur_row;
                c = cur_col;
                cur_col += even ? 1 : -1;
                if (!cell_is_reserved(r, c, rows, cols)) begin
                    res.placed  = 1'b1;
                    res.mod_row = t_coord'(r);
                    res.mod_col = t_coord'(c);
                    res.sym     = sym;
                    return 1'b1;
                end
            end
            // Step back inside the grid and turn onto the next row.
            cur_col += even ? -1 : 1;
            cur_row++;
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(bit quiet);
        int sel;
        sel = $urandom_range(0, 99);
        if (quiet || sel < 50) begin
            return 0;
        end else if (sel < 88) begin
            return $urandom_range(1, 3);
        end else if (sel < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // Offer one request and hold it until the block takes it.
    task automatic send_item(logic kind, t_sym sym, logic fixed, t_placement exp);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_symbol   <= sym;
        tag_fixed  <= fixed;
        tag_exp    <= exp;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering, wait for every expected placement, then let a
    // trailing start-frame request settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_placements.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(logic write, logic idx, t_grid value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= t_paddr'({idx, 2'b00});
        pwdata  <= t_pdata'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Monitor: register accesses, result checks and request prediction.
    always @(posedge i_clk) begin : monitor_blk
        t_placement got;
        t_placement want;
        t_placement pred;
        t_placement exp_res;
        t_grid      reg_val;
        if (!i_rst_n) begin
            grid_rows_m = smp_pkg::GridRowsReset;
            grid_cols_m = smp_pkg::GridColsReset;
            cur_row     = 0;
            cur_col     = 0;
            pending_placements.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[smp_pkg::ApbAddrBits-1:2] == smp_pkg::RegGridRows) begin
                        grid_rows_m = pwdata[smp_pkg::GridBits-1:0];
                    end else begin
                        grid_cols_m = pwdata[smp_pkg::GridBits-1:0];
                    end
                end else begin
                    reg_val = (paddr[smp_pkg::ApbAddrBits-1:2] == smp_pkg::RegGridRows)
                              ? grid_rows_m : grid_cols_m;
                    report_field("prdata", 32'(reg_val), 32'(prdata));
                end
            end
            if (o_out_valid && i_out_ready) begin
                got = '{o_placed, o_module_row, o_module_col, o_symbol_out};
                if (pending_placements.size() == 0) begin
                    $error("unexpected placement: placed %0d row %0d col %0d symbol %0d",
                           got.placed, got.mod_row, got.mod_col, got.sym);
                    err_count++;
                end else begin
                    want = pending_placements.pop_front();
                    report_field("placed",     32'(want.placed),  32'(got.placed));
                    report_field("module_row", 32'(want.mod_row), 32'(got.mod_row));
                    report_field("module_col", 32'(want.mod_col), 32'(got.mod_col));
                    report_field("symbol_out", 32'(want.sym),     32'(got.sym));
                end
            end
            if (i_in_valid && o_in_ready) begin
                if (place_symbol(i_kind, i_symbol, pred)) begin
                    exp_res = tag_fixed ? tag_exp : pred;
                    pending_placements.insert(pending_placements.size(), exp_res);
                end
            end
        end
    end

    // Receiver: runs of ready broken by stalls, plus a long hold-off when
    // the sender asks for one.
    initial begin : receiver_blk
        int run_left;
        int stall_left;
        int hold_left;
        run_left    = 0;
        stall_left  = 0;
        hold_left   = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (run_left > 0) begin
                i_out_ready <= 1'b1;
                run_left--;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    run_left   = $urandom_range(40, 150);
                    stall_left = 0;
                end else begin
                    run_left   = $urandom_range(0, 12);
                    stall_left = pick_gap(1'b0);
                end
            end
        end
    end

    // Sender: directed table, then random phases of requests.
    initial begin : sender_blk
        t_stim_row rw;
        int        sent;
        int        phase;
        int        n_items;
        int        sel;
        int        which;
        t_grid     rows;
        t_grid     cols;
        err_count   = 0;
        cycle_count = 0;
        tx_quiet    = 1'b0;
        hold_req    = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind     <= smp_pkg::KindStartFrame;
        i_symbol   <= '0;
        tag_fixed  <= 1'b0;
        tag_exp    <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        for (int i = 0; i < $size(directed_tbl); i++) begin
            rw = directed_tbl[i];
            case (rw.act)
                ACT_ITEM: begin
                    send_item(rw.kind, rw.sym, rw.fixed, rw.exp);
                end
                ACT_WRITE_ROWS: begin
                    wait_drained();
                    apb_access(1'b1, smp_pkg::RegGridRows, rw.cfg_val);
                    apb_access(1'b0, smp_pkg::RegGridRows, '0);
                end
                default: begin
                    wait_drained();
                    apb_access(1'b1, smp_pkg::RegGridCols, rw.cfg_val);
                    apb_access(1'b0, smp_pkg::RegGridCols, '0);
                end
            endcase
        end

        // Random phases: a new geometry, then mostly a fresh frame filled
        // with symbols, with the odd stray start-frame request.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drained();
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                rows = t_grid'($urandom_range(17, 24));
                cols = t_grid'($urandom_range(17, 28));
            end else if (sel < 60) begin
                rows = t_grid'($urandom_range(25, 120));
                cols = t_grid'($urandom_range(25, 120));
            end else if (sel < 72) begin
                rows = $urandom_range(0, 1) ? 8'd255 : 8'd17;
                cols = $urandom_range(0, 1) ? 8'd255 : 8'd17;
            end else if (sel < 80) begin
                rows = smp_pkg::GridRowsReset;
                cols = smp_pkg::GridColsReset;
            end else if (sel < 88) begin
                rows = t_grid'($urandom_range(0, 16));
                cols = t_grid'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) begin
                    {rows, cols} = {cols, rows};
                end
            end else begin
                rows = t_grid'($urandom_range(0, 255));
                cols = t_grid'($urandom_range(0, 255));
            end
            which = $urandom_range(0, 5);
            if (which != 1) begin
                apb_access(1'b1, smp_pkg::RegGridRows, rows);
            end
            if (which != 0) begin
                apb_access(1'b1, smp_pkg::RegGridCols, cols);
            end
            if ($urandom_range(0, 2) == 0) begin
                apb_access(1'b0, $urandom_range(0, 1) ? smp_pkg::RegGridCols
                                                      : smp_pkg::RegGridRows, '0);
            end

            tx_quiet = ($urandom_range(0, 4) == 0);
            n_items  = $urandom_range(20, 120);
            // Every so often the receiver holds off while requests keep coming.
            if (phase % 12 == 0) begin
                tx_quiet = 1'b1;
                n_items  = $urandom_range(60, 120);
                hold_req = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                send_item(smp_pkg::KindStartFrame, t_sym'($urandom_range(0, 3)), 1'b0,
                          FRAME_FULL);
                sent++;
            end
            repeat (n_items) begin
                send_item(($urandom_range(0, 24) == 0) ? smp_pkg::KindStartFrame
                                                       : smp_pkg::KindSymbol,
                          t_sym'($urandom_range(0, 3)), 1'b0, FRAME_FULL);
                sent++;
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
